### hw/rtl/pmc_pkg.sv
// shared types, constants and elaboration-time tables of the poisson mixture component
package pmc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int RATE_W        = 8 + FRAC_BITS;
  localparam int SUM_W         = 48;
  localparam int LL_W          = 41;
  localparam int WEIGHT_W      = 32;
  localparam int CNT_W         = 6;
  localparam int IDX_W         = 6;
  localparam int LNF_W         = 28;
  localparam int MAX_IDX_DEPTH = 1 << IDX_W;
  localparam int DIV_STEPS     = RATE_W;
  localparam int LN_GUARD      = FRAC_BITS + 2;
  localparam int RND_SHIFT     = LN_GUARD + 30 - FRAC_BITS;
  localparam int STEP_W        = 5;
  localparam int NEURONS_DEF   = 64;
  localparam int MAX_COUNT_DEF = 63;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_HALF = RATE_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [LL_W-1:0] LL_MIN = {1'b1, {(LL_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_ACC    = 2'd0,
    REQ_SCORE  = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_ADD,
    ST_UPD_RD,
    ST_UPD_DIV_INIT,
    ST_UPD_DIV,
    ST_UPD_LN_INIT,
    ST_UPD_SQ,
    ST_UPD_NORM,
    ST_UPD_LN_MUL,
    ST_UPD_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic acc_rd;
    logic acc_wr;
    logic sc_mul;
    logic sc_add;
    logic div_init;
    logic div_step;
    logic ln_init;
    logic sq_mul;
    logic sq_norm;
    logic ln_mul;
    logic upd_wr;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    logic norm_zero;
    logic last_entry;
  } stat_t;

  typedef logic [LNF_W-1:0] lnf_tab_t [0:255];

  // natural log of an unsigned q8.16 rate, elaboration use only
  function automatic logic signed [RATE_W-1:0] fx_ln_c(input logic [63:0] r);
    logic [63:0] rr;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] rnd;
    longint lg;
    int p;
    rr = r & 64'(RATE_MAX);
    p = 0;
    if (rr == 64'd0) return '0;
    for (int i = 0; i < RATE_W; i++) if (rr[i]) p = i;
    m = rr << (31 - p);
    lg = longint'(p - FRAC_BITS) * (longint'(1) << LN_GUARD);
    for (int i = LN_GUARD - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        lg = lg + (longint'(1) << i);
      end
    end
    mag = (lg < 0) ? 64'(-lg) : 64'(lg);
    prod = mag * 64'(LN2_Q30);
    rnd = (prod + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    return (lg < 0) ? -RATE_W'(rnd) : RATE_W'(rnd);
  endfunction

  function automatic lnf_tab_t build_lnfact();
    lnf_tab_t tab;
    longint acc;
    acc = 0;
    for (int k = 0; k < 256; k++) begin
      if (k >= 2) acc = acc + longint'(fx_ln_c(64'(k) << FRAC_BITS));
      tab[k] = LNF_W'(acc);
    end
    return tab;
  endfunction

  localparam logic signed [RATE_W-1:0] LN_HALF = fx_ln_c(64'd1 << (FRAC_BITS - 1));
  localparam lnf_tab_t LN_FACT = build_lnfact();

endpackage

### hw/rtl/pmc_ram.sv
// generic single write, single read ram with registered read data
module pmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [0:Depth-1];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/pmc_ctrl.sv
// request sequencer of the poisson mixture component
module pmc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     req_type_i,
  input  pmc_pkg::stat_t st_i,
  output logic           busy_o,
  output pmc_pkg::ctrl_t cmd_o
);
  import pmc_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_e'(req_type_i))
            REQ_ACC:    state_d = ST_ACC_RD;
            REQ_SCORE:  state_d = ST_SC_RD;
            REQ_UPDATE: state_d = st_i.norm_zero ? ST_RESP : ST_UPD_RD;
            REQ_CLEAR:  state_d = ST_RESP;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD:       state_d = ST_ACC_WR;
      ST_ACC_WR:       state_d = ST_RESP;
      ST_SC_RD:        state_d = ST_SC_MUL;
      ST_SC_MUL:       state_d = ST_SC_ADD;
      ST_SC_ADD:       state_d = ST_RESP;
      ST_UPD_RD:       state_d = ST_UPD_DIV_INIT;
      ST_UPD_DIV_INIT: begin
        state_d = ST_UPD_DIV;
        step_d  = '0;
      end
      ST_UPD_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_UPD_LN_INIT;
      end
      ST_UPD_LN_INIT: begin
        state_d = ST_UPD_SQ;
        step_d  = '0;
      end
      ST_UPD_SQ:       state_d = ST_UPD_NORM;
      ST_UPD_NORM: begin
        step_d = step_q + STEP_W'(1);
        state_d = (step_q == STEP_W'(LN_GUARD - 1)) ? ST_UPD_LN_MUL : ST_UPD_SQ;
      end
      ST_UPD_LN_MUL:   state_d = ST_UPD_WR;
      ST_UPD_WR:       state_d = st_i.last_entry ? ST_RESP : ST_UPD_RD;
      ST_RESP:         state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == ST_IDLE) && start_i;
    cmd_o.acc_rd   = (state_q == ST_ACC_RD);
    cmd_o.acc_wr   = (state_q == ST_ACC_WR);
    cmd_o.sc_mul   = (state_q == ST_SC_MUL);
    cmd_o.sc_add   = (state_q == ST_SC_ADD);
    cmd_o.div_init = (state_q == ST_UPD_DIV_INIT);
    cmd_o.div_step = (state_q == ST_UPD_DIV);
    cmd_o.ln_init  = (state_q == ST_UPD_LN_INIT);
    cmd_o.sq_mul   = (state_q == ST_UPD_SQ);
    cmd_o.sq_norm  = (state_q == ST_UPD_NORM);
    cmd_o.ln_mul   = (state_q == ST_UPD_LN_MUL);
    cmd_o.upd_wr   = (state_q == ST_UPD_WR);
    cmd_o.respond  = (state_q == ST_RESP);
    busy_o         = (state_q != ST_IDLE);
  end

endmodule

### hw/rtl/pmc_datapath.sv
// statistics, rate tables, divider, log unit and score accumulator
module pmc_datapath #(
  parameter int Neurons  = pmc_pkg::NEURONS_DEF,
  parameter int MaxCount = pmc_pkg::MAX_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmc_pkg::ctrl_t               cmd_i,
  output pmc_pkg::stat_t               st_o,
  input  logic [1:0]                   req_type_i,
  input  logic [pmc_pkg::IDX_W-1:0]    neuron_index_i,
  input  logic [pmc_pkg::CNT_W-1:0]    spike_count_i,
  input  logic [pmc_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                         last_i,
  output logic                         done_o,
  output logic signed [pmc_pkg::LL_W-1:0] log_likelihood_o,
  output logic                         impossible_o,
  output logic                         status_o,
  output logic [1:0]                   op_done_o
);
  import pmc_pkg::*;

  localparam int Depth = (Neurons < MAX_IDX_DEPTH) ? Neurons : MAX_IDX_DEPTH;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // latched request
  req_e                req_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                last_q;
  logic                idx_ok_q;
  logic                refused_q;
  logic [CNT_W-1:0]    cnt_sat;
  logic [AddrW-1:0]    addr;

  // persistent state
  logic [Depth-1:0]         sum_valid_q;
  logic [SUM_W-1:0]         norm_q;
  logic                     rates_init_q;
  logic signed [LL_W-1:0]   partial_q, partial_d;
  logic                     zero_hit_q;
  logic [AddrW-1:0]         entry_q;

  // ram ports
  logic [SUM_W-1:0]  sum_rdata, sum_wdata;
  logic [AddrW-1:0]  sum_raddr;
  logic              sum_we;
  logic [RATE_W-1:0] rate_rdata, log_rdata, rate_wdata, log_wdata;

  // accumulate
  logic [SUM_W-1:0]  sum_in;
  logic [37:0]       acc_prod_q;
  logic [SUM_W:0]    sum_wide, norm_wide;

  // score
  logic [RATE_W-1:0]        rate_sel, rate_q;
  logic [RATE_W-1:0]        log_sel;
  logic signed [30:0]       cprod_q;
  logic [LNF_W-1:0]         lf_q;
  logic signed [33:0]       term, term_c;
  logic signed [LL_W:0]     score_sum;

  // divider
  logic [SUM_W+8-1:0]  den;
  logic [SUM_W+8:0]    rem_q, rem_sh;
  logic [RATE_W-1:0]   quo_q;
  logic                sat_q;

  // log unit
  logic [RATE_W-1:0]      rate_new_q, rate_pick;
  logic [4:0]             msb_pos;
  logic [31:0]            m_q;
  logic [63:0]            sq_q;
  logic [32:0]            sq_top;
  logic signed [5:0]      intp_q;
  logic [LN_GUARD-1:0]    frac_q;
  logic signed [24:0]     lg;
  logic [22:0]            lg_mag;
  logic [52:0]            lnprod_q, ln_rnd;
  logic                   lneg_q;
  logic [20:0]            ln_abs;

  assign cnt_sat = (int'(spike_count_i) > MaxCount) ? CNT_W'(MaxCount) : spike_count_i;
  assign addr    = idx_q[AddrW-1:0];

  assign st_o.norm_zero  = (norm_q == '0);
  assign st_o.last_entry = (entry_q == AddrW'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q     <= req_e'(req_type_i);
      idx_q     <= neuron_index_i;
      cnt_q     <= cnt_sat;
      weight_q  <= weight_i;
      last_q    <= last_i;
      idx_ok_q  <= (int'(neuron_index_i) < Neurons);
      refused_q <= (norm_q == '0);
    end
  end

  // sums memory
  assign sum_raddr = (req_q == REQ_UPDATE) ? entry_q : addr;
  assign sum_in    = sum_valid_q[sum_raddr] ? sum_rdata : '0;
  assign sum_wide  = {1'b0, sum_in} + (SUM_W + 1)'(acc_prod_q);
  assign sum_wdata = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign sum_we    = cmd_i.acc_wr && idx_ok_q;
  assign norm_wide = {1'b0, norm_q} + (SUM_W + 1)'(weight_q);

  pmc_ram #(.Width(SUM_W), .Depth(Depth)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (addr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  pmc_ram #(.Width(RATE_W), .Depth(Depth)) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd_wr),
    .waddr_i (entry_q),
    .wdata_i (rate_wdata),
    .raddr_i (addr),
    .rdata_o (rate_rdata)
  );

  pmc_ram #(.Width(RATE_W), .Depth(Depth)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd_wr),
    .waddr_i (entry_q),
    .wdata_i (log_wdata),
    .raddr_i (addr),
    .rdata_o (log_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_rd) acc_prod_q <= 38'(cnt_q) * 38'(weight_q);
  end

  // score path
  assign rate_sel = rates_init_q ? rate_rdata : RATE_HALF;
  assign log_sel  = rates_init_q ? log_rdata  : LN_HALF;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_mul) begin
      rate_q  <= rate_sel;
      cprod_q <= 31'($signed({1'b0, cnt_q}) * $signed(log_sel));
      lf_q    <= LN_FACT[{2'b00, cnt_q}];
    end
  end

  assign term      = 34'(cprod_q) - $signed({10'b0, rate_q}) - $signed({6'b0, lf_q});
  assign term_c    = term[33] ? term : '0;
  assign score_sum = {partial_q[LL_W-1], partial_q} + (LL_W + 1)'(term_c);

  always_comb begin
    partial_d = partial_q;
    if (score_sum[LL_W:LL_W-1] == 2'b10) partial_d = LL_MIN;
    else partial_d = score_sum[LL_W-1:0];
  end

  // restoring divider, one quotient bit a cycle
  assign den    = {norm_q, 8'b0};
  assign rem_sh = {rem_q[SUM_W+8-1:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      sat_q <= ({8'b0, sum_in} >= den);
      rem_q <= (SUM_W + 9)'(sum_in);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_q <= rem_sh - {1'b0, den};
        quo_q <= {quo_q[RATE_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[RATE_W-2:0], 1'b0};
      end
    end
  end

  // log2 by repeated squaring of the mantissa
  assign rate_pick = sat_q ? RATE_MAX : quo_q;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < RATE_W; i++) if (rate_pick[i]) msb_pos = 5'(i);
  end

  assign sq_top = sq_q[63:31];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ln_init) begin
      rate_new_q <= rate_pick;
      m_q        <= 32'({8'b0, rate_pick} << (5'd31 - msb_pos));
      intp_q     <= $signed({1'b0, msb_pos}) - 6'sd16;
      frac_q     <= '0;
    end
    if (cmd_i.sq_mul) sq_q <= 64'(m_q) * 64'(m_q);
    if (cmd_i.sq_norm) begin
      if (sq_top[32]) begin
        m_q    <= sq_top[32:1];
        frac_q <= {frac_q[LN_GUARD-2:0], 1'b1};
      end else begin
        m_q    <= sq_top[31:0];
        frac_q <= {frac_q[LN_GUARD-2:0], 1'b0};
      end
    end
    if (cmd_i.ln_mul) begin
      lnprod_q <= 53'(lg_mag) * 53'(LN2_Q30);
      lneg_q   <= lg[24];
    end
  end

  assign lg     = $signed({intp_q[5], intp_q, {LN_GUARD{1'b0}}}) + $signed({7'b0, frac_q});
  assign lg_mag = lg[24] ? 23'(-lg) : lg[22:0];
  assign ln_rnd = lnprod_q + (53'd1 << (RND_SHIFT - 1));
  assign ln_abs = ln_rnd[RND_SHIFT+20:RND_SHIFT];

  assign rate_wdata = rate_new_q;
  assign log_wdata  = (rate_new_q == '0) ? '0 :
                      (lneg_q ? -{3'b0, ln_abs} : {3'b0, ln_abs});

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q  <= '0;
      norm_q       <= '0;
      rates_init_q <= 1'b0;
      partial_q    <= '0;
      zero_hit_q   <= 1'b0;
      entry_q      <= '0;
      done_o       <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cmd_i.latch) entry_q <= '0;
      if (sum_we) sum_valid_q[addr] <= 1'b1;
      if (cmd_i.acc_wr && last_q)
        norm_q <= norm_wide[SUM_W] ? {SUM_W{1'b1}} : norm_wide[SUM_W-1:0];
      if (cmd_i.sc_add && idx_ok_q) begin
        if (rate_q == '0 && cnt_q != '0) begin
          zero_hit_q <= 1'b1;
          partial_q  <= LL_MIN;
        end else begin
          partial_q <= partial_d;
        end
      end
      if (cmd_i.upd_wr) begin
        entry_q <= entry_q + AddrW'(1);
        if (st_o.last_entry) rates_init_q <= 1'b1;
      end
      if (cmd_i.respond) begin
        done_o <= ((req_q == REQ_ACC) || (req_q == REQ_SCORE)) ? last_q : 1'b1;
        if (req_q == REQ_SCORE && last_q) begin
          partial_q  <= '0;
          zero_hit_q <= 1'b0;
        end
        if (req_q == REQ_CLEAR) begin
          sum_valid_q <= '0;
          norm_q      <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      log_likelihood_o <= (req_q == REQ_SCORE) ? partial_q : '0;
      impossible_o     <= (req_q == REQ_SCORE) ? zero_hit_q : 1'b0;
      status_o         <= (req_q == REQ_UPDATE) ? refused_q : 1'b0;
      op_done_o        <= req_q;
    end
  end

endmodule

### hw/rtl/poisson_mixture_component_core.sv
// top level of one poisson mixture component
// A request is taken when start_i is high and busy_o is low; a result comes as a one-cycle
// done_o strobe that the receiver cannot hold off. Update walks every entry (min(NEURONS, 64)
// of them) through a restoring divider (one quotient bit a cycle) and a log unit (18
// squarings, each a square step then a normalise step); a refused update (zero normaliser)
// goes straight to the response. Accumulate and score give a result only on the last item.
module poisson_mixture_component_core #(
  parameter int NEURONS   = pmc_pkg::NEURONS_DEF,
  parameter int MAX_COUNT = pmc_pkg::MAX_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [pmc_pkg::IDX_W-1:0]    neuron_index_i,
  input  logic [pmc_pkg::CNT_W-1:0]    spike_count_i,
  input  logic [pmc_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                         last_i,
  output logic                         done_o,
  output logic signed [pmc_pkg::LL_W-1:0] log_likelihood_o,
  output logic                         impossible_o,
  output logic                         status_o,
  output logic [1:0]                   op_done_o
);
  import pmc_pkg::*;

  ctrl_t cmd;
  stat_t st;

  pmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .st_i       (st),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  pmc_datapath #(.Neurons(NEURONS), .MaxCount(MAX_COUNT)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .req_type_i       (req_type_i),
    .neuron_index_i   (neuron_index_i),
    .spike_count_i    (spike_count_i),
    .weight_i         (weight_i),
    .last_i           (last_i),
    .done_o           (done_o),
    .log_likelihood_o (log_likelihood_o),
    .impossible_o     (impossible_o),
    .status_o         (status_o),
    .op_done_o        (op_done_o)
  );

endmodule

### hw/rtl/pmc_checker.sv
// port-level checks of the poisson mixture component and their binding
module pmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic signed [pmc_pkg::LL_W-1:0] log_likelihood_o,
  input logic                         impossible_o,
  input logic                         status_o,
  input logic [1:0]                   op_done_o
);
  import pmc_pkg::*;

  // a result only shows once the request has finished
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o)) else $error("request not taken up");

  a_score_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_done_o != REQ_SCORE) |-> (log_likelihood_o == '0 && !impossible_o))
    else $error("score fields set on a non-score result");

  a_status_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_done_o != REQ_UPDATE) |-> !status_o) else $error("status on non-update");

  a_ll_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_done_o == REQ_SCORE) |-> (log_likelihood_o[LL_W-1] || log_likelihood_o == '0))
    else $error("positive log likelihood");

endmodule

bind poisson_mixture_component_core pmc_checker u_pmc_checker (.*);
